// ===== design/sorted_table_binary_search_top_defines.svh =====
// Assertion helpers used by the search controller.
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define BSRCH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BSRCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);

`endif

// ===== design/bsrch_pkg.sv =====
package bsrch_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned INDEX_W     = 10;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned POS_W       = 10;
  // search bounds: low up to TABLE_DEPTH, high down to -1
  localparam int unsigned BOUND_W     = ADDR_W + 2;
  localparam int unsigned CLAMP_W     = (COUNT_W > ADDR_W + 1) ? COUNT_W : ADDR_W + 1;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                      kind;
    logic [INDEX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0]   entry_value;
    logic signed [DATA_W-1:0]   search_key;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   position;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EMPTY
  } state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic emit;
    logic emit_empty;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic done;
  } dp_status_t;

endpackage

// ===== design/bsrch_ram.sv =====
module bsrch_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bsrch_ctrl.sv =====
`include "sorted_table_binary_search_top_defines.svh"

module bsrch_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  bsrch_pkg::kind_e      in_kind_i,
  output logic                  in_ready_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  input  bsrch_pkg::dp_status_t status_i,
  output bsrch_pkg::dp_cmd_t    cmd_o
);

  bsrch_pkg::state_e state_q, state_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              set_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsrch_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    set_out    = 1'b0;
    // output slot can take a result this cycle
    out_free   = !out_valid_q || out_ready_i;
    unique case (state_q)
      bsrch_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == bsrch_pkg::KIND_LOAD) begin
            cmd_o.load = 1'b1;
          end else if (status_i.count_zero) begin
            state_d = bsrch_pkg::ST_EMPTY;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = bsrch_pkg::ST_CMP;
          end
        end
      end
      bsrch_pkg::ST_EMPTY: begin
        if (out_free) begin
          cmd_o.emit_empty = 1'b1;
          set_out          = 1'b1;
          state_d          = bsrch_pkg::ST_IDLE;
        end
      end
      bsrch_pkg::ST_CMP: begin
        // on a full output slot the probe data is simply held
        if (status_i.done) begin
          if (out_free) begin
            cmd_o.emit = 1'b1;
            set_out    = 1'b1;
            state_d    = bsrch_pkg::ST_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        state_d = bsrch_pkg::ST_IDLE;
      end
    endcase
    out_valid_d = set_out || (out_valid_q && !out_ready_i);
  end

  assign out_valid_o = out_valid_q;

  `BSRCH_ASSERT(a_emit_slot_free, (cmd_o.emit || cmd_o.emit_empty) |-> (!out_valid_q || out_ready_i), "result written over a pending item")
  `BSRCH_ASSERT(a_step_not_done, cmd_o.step |-> !status_i.done, "probe step after search end")
  `BSRCH_ASSERT_NEXT(a_start_to_cmp, cmd_o.start, state_q == bsrch_pkg::ST_CMP, "search start did not enter compare")
  `BSRCH_ASSERT(a_busy_no_accept, (state_q != bsrch_pkg::ST_IDLE) |-> !(cmd_o.load || cmd_o.start), "item taken while busy")

endmodule

// ===== design/bsrch_dp.sv =====
module bsrch_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bsrch_pkg::COUNT_W-1:0]  cfg_data_i,
  input  bsrch_pkg::in_item_t            in_item_i,
  input  bsrch_pkg::dp_cmd_t             cmd_i,
  output bsrch_pkg::dp_status_t          status_o,
  output bsrch_pkg::out_item_t           out_item_o
);

  localparam int unsigned ADDR_W  = bsrch_pkg::ADDR_W;
  localparam int unsigned BOUND_W = bsrch_pkg::BOUND_W;
  localparam int unsigned CLAMP_W = bsrch_pkg::CLAMP_W;
  localparam int unsigned DATA_W  = bsrch_pkg::DATA_W;
  localparam logic signed [BOUND_W-1:0] BoundOne = BOUND_W'(1);

  logic [bsrch_pkg::COUNT_W-1:0] entry_count_q;
  logic signed [DATA_W-1:0]      key_q;
  logic signed [BOUND_W-1:0]     low_q, high_q;
  logic [ADDR_W-1:0]             mid_q;
  bsrch_pkg::out_item_t          out_item_q;

  logic [DATA_W-1:0]             ram_rdata;
  logic signed [DATA_W-1:0]      probe;
  logic                          probe_lt, probe_eq;
  logic [CLAMP_W-1:0]            count_cl;
  logic signed [BOUND_W-1:0]     high_init, mid_s, low_n, high_n;
  logic signed [BOUND_W:0]       sum_n;
  logic [ADDR_W-1:0]             mid_init, mid_next, ram_addr;
  logic                          ram_we, ram_re;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_data_i;
    end
  end

  always_comb begin
    count_cl = CLAMP_W'(entry_count_q);
    if (count_cl > CLAMP_W'(bsrch_pkg::TABLE_DEPTH)) begin
      count_cl = CLAMP_W'(bsrch_pkg::TABLE_DEPTH);
    end
    high_init = $signed(BOUND_W'(count_cl)) - BoundOne;
    mid_init  = ADDR_W'((count_cl - CLAMP_W'(1)) >> 1);

    probe    = $signed(ram_rdata);
    probe_eq = (probe == key_q);
    probe_lt = (probe < key_q);
    mid_s    = $signed({2'b00, mid_q});
    low_n    = probe_lt ? mid_s + BoundOne : low_q;
    high_n   = (!probe_lt && !probe_eq) ? mid_s - BoundOne : high_q;
    sum_n    = low_n + high_n;
    mid_next = sum_n[ADDR_W:1];

    status_o.count_zero = (entry_count_q == '0);
    status_o.done       = probe_eq || (high_n < low_n);

    ram_we = cmd_i.load &&
             (32'(in_item_i.entry_index) < 32'(bsrch_pkg::TABLE_DEPTH));
    ram_re = cmd_i.start || cmd_i.step;
    priority if (cmd_i.load) begin
      ram_addr = ADDR_W'(in_item_i.entry_index);
    end else if (cmd_i.start) begin
      ram_addr = mid_init;
    end else begin
      ram_addr = mid_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q  <= in_item_i.search_key;
      low_q  <= '0;
      high_q <= high_init;
      mid_q  <= mid_init;
    end else if (cmd_i.step) begin
      low_q  <= low_n;
      high_q <= high_n;
      mid_q  <= mid_next;
    end
    if (cmd_i.emit) begin
      out_item_q.found    <= probe_eq;
      out_item_q.position <= bsrch_pkg::POS_W'(mid_q);
    end else if (cmd_i.emit_empty) begin
      out_item_q <= '0;
    end
  end

  bsrch_ram #(
    .WIDTH (DATA_W),
    .DEPTH (bsrch_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (in_item_i.entry_value),
    .rdata_o (ram_rdata)
  );

  assign out_item_o = out_item_q;

endmodule

// ===== design/sorted_table_binary_search_top.sv =====
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+---------------------------
// in       | input     | in_valid_i/in_ready_o  | in_item_i (load or query)
// out      | output    | out_valid_o/out_ready_i| out_item_o (found,position)
// cfg      | input     | cfg_we_i               | cfg_data_i (entry_count)
//
// Load item: written to the table RAM at the edge that accepts it.
// Query item: one probe per cycle through the single RAM read port,
// 1 to 11 probes for 1024 entries; the result register takes it once the
// last compare is done and the output slot is free. Empty table: no probes.
// rst_ni clears the state machine, output valid and entry_count; the table
// holds whatever was loaded. A stalled output holds the last probe in place.
module sorted_table_binary_search_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bsrch_pkg::COUNT_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bsrch_pkg::in_item_t           in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bsrch_pkg::out_item_t          out_item_o
);

  bsrch_pkg::dp_cmd_t    cmd;
  bsrch_pkg::dp_status_t status;

  bsrch_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_item_i.kind),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bsrch_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

endmodule

// ===== bench/sorted_table_binary_search_checker.sv =====
module sorted_table_binary_search_checker
  import bsrch_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [COUNT_W-1:0]   cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_item_t             in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_item_t            out_item_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          pending_o
);

  logic signed [DATA_W-1:0] shadow_table [TABLE_DEPTH];
  logic [COUNT_W-1:0]       shadow_count;
  out_item_t                expected_lookups [$];
  int unsigned              mismatches = 0;

  // Iterative search over the shadow table; a miss reports the last midpoint.
  function automatic out_item_t predict_lookup(input logic signed [DATA_W-1:0] key);
    int        lo;
    int        hi;
    int        mid;
    out_item_t res;
    lo        = 0;
    hi        = (shadow_count > TABLE_DEPTH) ? int'(TABLE_DEPTH) - 1
                                              : int'(shadow_count) - 1;
    mid       = 0;
    res.found = 1'b0;
    while (hi >= lo && !res.found) begin
      mid = (lo + hi) / 2;
      if (shadow_table[mid] == key) begin
        res.found = 1'b1;
      end else if (shadow_table[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    res.position = mid[POS_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      shadow_count = '0;
      expected_lookups.delete();
      pending_o        <= 0;
      mismatch_count_o <= 0;
    end else begin
      // Retire results first so a query taken at this edge cannot match one.
      if (out_valid_i && out_ready_i) begin
        if (expected_lookups.size() == 0) begin
          $error("result with no query pending: found %0d, position %0d",
                 out_item_i.found, out_item_i.position);
          mismatches++;
        end else begin
          want = expected_lookups.pop_front();
          if (out_item_i.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, out_item_i.found);
            mismatches++;
          end
          if (out_item_i.position !== want.position) begin
            $error("position: expected %0d, actual %0d",
                   want.position, out_item_i.position);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_item_i.kind == KIND_LOAD) begin
          if (in_item_i.entry_index < TABLE_DEPTH)
            shadow_table[in_item_i.entry_index] = in_item_i.entry_value;
        end else begin
          expected_lookups.push_back(predict_lookup(in_item_i.search_key));
        end
      end
      if (cfg_we_i)
        shadow_count = cfg_data_i;
      pending_o        <= expected_lookups.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

// ===== bench/tb_sorted_table_binary_search_top.sv =====
module tb_sorted_table_binary_search_top;
  import bsrch_pkg::*;

  localparam int unsigned              STUCK_LIMIT  = 2000;
  localparam int unsigned              SETTLE_TICKS = 16;
  localparam logic signed [DATA_W-1:0] VAL_MIN      = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX      = 32'sh7fff_ffff;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [COUNT_W-1:0] cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_item_t           in_item_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_item_t          out_item_o;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned tx_idle_pct = 19;
  int unsigned rx_idle_pct = 81;
  int unsigned current_count = 0;
  int unsigned stuck_cycles = 0;

  // What the stimulus has written, used to aim queries at hits and near misses.
  logic signed [DATA_W-1:0] loaded_value [TABLE_DEPTH];

  sorted_table_binary_search_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  sorted_table_binary_search_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_item_i        (in_item_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_item_i       (out_item_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("sorted_table_binary_search_top verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Within this task valid is only lowered for a gap, so back-to-back items never toggle it.
  task automatic send_item(input in_item_t item);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_load(input int unsigned idx, input logic signed [DATA_W-1:0] val);
    in_item_t item;
    item.kind        = KIND_LOAD;
    item.entry_index = idx[INDEX_W-1:0];
    item.entry_value = val;
    item.search_key  = $urandom;
    loaded_value[idx] = val;
    send_item(item);
  endtask

  task automatic send_query(input logic signed [DATA_W-1:0] key);
    in_item_t item;
    item.kind        = KIND_QUERY;
    item.entry_index = INDEX_W'($urandom_range(TABLE_DEPTH - 1));
    item.entry_value = $urandom;
    item.search_key  = key;
    send_item(item);
  endtask

  // Pending is a registered copy of the checker's queue size, hence the extra edge first.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic program_entry_count(input int unsigned count);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= COUNT_W'(count);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    current_count = count;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_key();
    int unsigned              span;
    int unsigned              sel;
    logic signed [DATA_W-1:0] base;
    span = (current_count > TABLE_DEPTH) ? TABLE_DEPTH : current_count;
    sel  = $urandom_range(99);
    if (sel < 15 || span == 0) return $urandom;
    base = loaded_value[$urandom_range(span - 1)];
    if (sel < 60) return base;
    if (sel < 80) return $urandom_range(1) ? base + 1 : base - 1;
    case ($urandom_range(3))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return loaded_value[0] - 1;
      default: return loaded_value[span - 1] + 1;
    endcase
  endfunction

  initial begin
    longint                   acc;
    longint                   lo_v;
    longint                   hi_v;
    int unsigned              idx;
    int unsigned              cnt;
    int unsigned              r;
    logic signed [DATA_W-1:0] val;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table: no probes, answer is a miss at index zero.
    program_entry_count(0);
    send_query(VAL_MIN);
    send_query(VAL_MAX);

    send_load(0, VAL_MIN);
    send_load(1, -1000);
    send_load(2, 0);
    send_load(3, 0);
    send_load(4, 1000);
    send_load(5, VAL_MAX);
    send_load(TABLE_DEPTH - 1, VAL_MAX);

    program_entry_count(1);
    send_query(VAL_MIN);
    send_query(5);

    program_entry_count(6);
    send_query(VAL_MIN);
    send_query(VAL_MAX);
    send_query(0);
    send_query(-1000);
    send_query(1);
    send_query(VAL_MIN + 1);
    send_query(VAL_MAX - 1);

    // Fill the whole table in ascending order so any count is safe to search.
    acc = VAL_MIN;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == TABLE_DEPTH - 1) acc = VAL_MAX;
      send_load(i, acc[DATA_W-1:0]);
      acc = acc + $urandom_range(4000000);
      if (acc > VAL_MAX) acc = VAL_MAX;
    end

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          tx_idle_pct = 19;
          rx_idle_pct = 81;
        end
        1: begin
          tx_idle_pct = 81;
          rx_idle_pct = 19;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 5; s++) begin
        case (s)
          0:       cnt = 1;
          1:       cnt = $urandom_range(16, 2);
          2:       cnt = $urandom_range(TABLE_DEPTH - 1, 17);
          3:       cnt = TABLE_DEPTH;
          default: cnt = (mode == 0) ? 2047 : $urandom_range(2047, TABLE_DEPTH + 1);
        endcase
        program_entry_count(cnt);
        repeat (47) begin
          if ($urandom_range(59) == 0) drain_results();
          r = $urandom_range(99);
          if (r < 85) begin
            send_query(pick_key());
          end else if (r < 97) begin
            // rewrite an entry between its neighbors, keeping the order
            idx  = $urandom_range(TABLE_DEPTH - 2, 1);
            lo_v = loaded_value[idx - 1];
            hi_v = loaded_value[idx + 1];
            if (hi_v < lo_v) val = lo_v[DATA_W-1:0];
            else             val = DATA_W'(lo_v + $urandom_range(32'(hi_v - lo_v)));
            send_load(idx, val);
          end else begin
            send_load($urandom_range(TABLE_DEPTH - 1), $urandom);
          end
        end
      end
    end

    drain_results();
    if (mismatch_count == 0 && pending == 0) begin
      $display("sorted_table_binary_search_top verification clean");
    end else begin
      $display("sorted_table_binary_search_top verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/bsrch_pkg.sv
design/bsrch_ram.sv
design/bsrch_ctrl.sv
design/bsrch_dp.sv
design/sorted_table_binary_search_top.sv
bench/sorted_table_binary_search_checker.sv
bench/tb_sorted_table_binary_search_top.sv
